// File: hdl/wbss_pkg.sv
// Shared types and constants for the wildcard byte signature scanner.
package wbss_pkg;

	localparam int SIG_BYTES       = 16;
	localparam int MAX_PATTERN_DEF = 16;
	localparam int LEN_W           = 5;
	localparam int ADDR_W          = 64;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_IDX_W       = 3;
	localparam int MASK_W          = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REGION_START  = 3'd0,
		REG_SCAN_BACKWARD = 3'd1,
		REG_PATTERN_LOW   = 3'd2,
		REG_PATTERN_HIGH  = 3'd3,
		REG_WILDCARD_MASK = 3'd4,
		REG_PATTERN_LEN   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] match_address;
	} out_beat_t;

endpackage

// File: hdl/wildcard_byte_signature_scan.sv
// Top level of the wildcard byte signature scanner.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------
//  bytes    | byte_valid / byte_ready     | byte_beat   (data_byte, last_byte)
//  results  | result_valid / result_ready | result_beat (found, match_address)
//  config   | cfg_wr_en                   | cfg_index, cfg_data
//
// One byte per cycle while no blocked result holds stage 1. A byte shifts into the
// window on acceptance, is compared in stage 1 and its result, if any, is then
// registered in the result register. Reset clears the count, address, match state
// and valid flags and sets the configuration registers to defaults, not the window.
// A stalled result holds stage 1 only when stage 1 itself has a result to give.
module wildcard_byte_signature_scan #(
	parameter int MAX_PATTERN = wbss_pkg::MAX_PATTERN_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 byte_valid,
	output logic                                 byte_ready,
	input  wbss_pkg::in_beat_t                   byte_beat,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output wbss_pkg::out_beat_t                  result_beat,
	input  logic                                 cfg_wr_en,
	input  logic [wbss_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wbss_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int LEN_CAP = (MAX_PATTERN < wbss_pkg::SIG_BYTES) ? MAX_PATTERN
	                                                               : wbss_pkg::SIG_BYTES;
	localparam int WIN_IW  = (LEN_CAP > 1) ? $clog2(LEN_CAP) : 1;
	localparam int CNT_W   = $clog2(MAX_PATTERN + 1);
	localparam int CMP_W   = (CNT_W > wbss_pkg::LEN_W) ? CNT_W : wbss_pkg::LEN_W;
	localparam int AW      = wbss_pkg::ADDR_W;

	// configuration
	logic [AW-1:0]                  region_start_q;
	logic                           backward_q;
	logic [63:0]                    pat_lo_q;
	logic [63:0]                    pat_hi_q;
	logic [wbss_pkg::MASK_W-1:0]    mask_q;
	logic [wbss_pkg::LEN_W-1:0]     plen_q;

	// region state
	logic [7:0]       win_q [LEN_CAP];
	logic [CNT_W-1:0] cnt_q;
	logic [AW-1:0]    addr_q;
	logic             done_q;

	// stage 1
	logic             valid_s1;
	logic             last_s1;
	logic [CNT_W-1:0] cnt_s1;
	logic [AW-1:0]    addr_s1;

	// result register
	logic                 result_valid_q;
	wbss_pkg::out_beat_t  result_beat_q;

	logic                       accept;
	logic [CNT_W-1:0]           cnt_inc;
	logic [wbss_pkg::LEN_W-1:0] len;
	logic [127:0]               sig;
	logic                       win_hit;
	logic                       match;
	logic                       emit;
	logic                       s1_move;
	logic [AW-1:0]              found_addr;

	assign accept  = byte_valid && byte_ready;
	assign cnt_inc = (cnt_q == CNT_W'(MAX_PATTERN)) ? cnt_q : cnt_q + CNT_W'(1);
	assign sig     = {pat_hi_q, pat_lo_q};

	always_comb begin
		if (plen_q == '0) begin
			len = wbss_pkg::LEN_W'(1);
		end else if (plen_q > wbss_pkg::LEN_W'(LEN_CAP)) begin
			len = wbss_pkg::LEN_W'(LEN_CAP);
		end else begin
			len = plen_q;
		end
	end

	// Signature byte i sits at window slot i (backward) or len-1-i (forward).
	always_comb begin
		logic [wbss_pkg::LEN_W-1:0] slot;
		win_hit = 1'b1;
		slot    = '0;
		for (int i = 0; i < LEN_CAP; i++) begin
			slot = backward_q ? wbss_pkg::LEN_W'(i)
			                  : wbss_pkg::LEN_W'(len - wbss_pkg::LEN_W'(1) - wbss_pkg::LEN_W'(i));
			if (wbss_pkg::LEN_W'(i) < len && !mask_q[i]) begin
				if (win_q[slot[WIN_IW-1:0]] != sig[i*8 +: 8]) begin
					win_hit = 1'b0;
				end
			end
		end
	end

	assign match      = (CMP_W'(cnt_s1) >= CMP_W'(len)) && win_hit;
	assign emit       = valid_s1 && !done_q && (match || last_s1);
	assign s1_move    = valid_s1 && (!emit || !result_valid_q || result_ready);
	assign byte_ready = !valid_s1 || s1_move;
	assign found_addr = backward_q ? addr_s1
	                               : addr_s1 - AW'(len - wbss_pkg::LEN_W'(1));

	// configuration, counters and address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_start_q <= '0;
			backward_q     <= 1'b0;
			pat_lo_q       <= '0;
			pat_hi_q       <= '0;
			mask_q         <= '0;
			plen_q         <= wbss_pkg::LEN_W'(1);
			cnt_q          <= '0;
			addr_q         <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					wbss_pkg::REG_REGION_START: begin
						region_start_q <= cfg_data;
						if (cnt_q == '0) begin
							addr_q <= cfg_data;
						end
					end
					wbss_pkg::REG_SCAN_BACKWARD: backward_q <= cfg_data[0];
					wbss_pkg::REG_PATTERN_LOW:   pat_lo_q   <= cfg_data;
					wbss_pkg::REG_PATTERN_HIGH:  pat_hi_q   <= cfg_data;
					wbss_pkg::REG_WILDCARD_MASK: mask_q     <= cfg_data[wbss_pkg::MASK_W-1:0];
					wbss_pkg::REG_PATTERN_LEN:   plen_q     <= cfg_data[wbss_pkg::LEN_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				if (byte_beat.last_byte) begin
					cnt_q  <= '0;
					addr_q <= region_start_q;
				end else begin
					cnt_q  <= cnt_inc;
					addr_q <= backward_q ? addr_q - AW'(1) : addr_q + AW'(1);
				end
			end
		end
	end

	// window holds the newest byte in slot 0; stale slots are masked by the count
	always_ff @(posedge clk) begin
		if (accept) begin
			win_q[0] <= byte_beat.data_byte;
			for (int k = 1; k < LEN_CAP; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
	end

	// stage 1 and match state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (s1_move) begin
				done_q <= last_s1 ? 1'b0 : (done_q || match);
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= byte_beat.last_byte;
			cnt_s1  <= cnt_inc;
			addr_s1 <= addr_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_move && emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && emit) begin
			result_beat_q.found         <= match;
			result_beat_q.match_address <= match ? found_addr : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign result_beat  = result_beat_q;

	a_notfound_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_beat.found |-> result_beat.match_address == '0)
		else $error("not-found beat carries a nonzero address");

	a_region_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move && last_s1 |=> !done_q)
		else $error("match state survived the end of a region");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> valid_s1 && result_valid && !result_ready)
		else $error("byte channel stalled without a blocked result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_PATTERN))
		else $error("byte count passed its saturation point");

endmodule
